@@ design/wdb_pkg.sv @@
package wdb_pkg;

    // Screen geometry
    localparam int SCREEN_WIDTH   = 320;
    localparam int SCREEN_HEIGHT  = 200;
    localparam int TASKBAR_HEIGHT = 12;

    // Window decoration
    localparam int TITLE_HEIGHT   = 10;
    localparam int BUTTON_SIZE    = 8;
    localparam int FULL_BTN_OFS   = 30;
    localparam int MIN_BTN_OFS    = 20;
    localparam int CLOSE_BTN_OFS  = 10;

    // Velocity decay: 9/10 as x*9 then multiply by reciprocal of 10
    localparam int RECIP_SHIFT    = 19;
    localparam logic [15:0] RECIP_10 = 16'd52429;

    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 10;

    typedef logic signed [11:0] t_coord;
    typedef logic signed [13:0] t_wide;

    localparam t_wide SAT_HI      = t_wide'(2047);
    localparam t_wide SAT_LO      = t_wide'(-2048);
    localparam t_wide SCREEN_W_W  = t_wide'(SCREEN_WIDTH);
    localparam t_wide FLOOR_Y     = t_wide'(SCREEN_HEIGHT - TASKBAR_HEIGHT);
    localparam t_wide TITLE_H_W   = t_wide'(TITLE_HEIGHT);
    localparam t_wide BTN_W       = t_wide'(BUTTON_SIZE);
    localparam t_wide BTN_TOP_OFS = t_wide'(1);
    localparam t_wide FULL_OFS_W  = t_wide'(FULL_BTN_OFS);
    localparam t_wide MIN_OFS_W   = t_wide'(MIN_BTN_OFS);
    localparam t_wide CLOSE_OFS_W = t_wide'(CLOSE_BTN_OFS);
    localparam t_coord FULL_W     = t_coord'(SCREEN_WIDTH);
    localparam t_coord FULL_H     = t_coord'(SCREEN_HEIGHT - TASKBAR_HEIGHT);

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_MOUSE  = 2'd1,
        FUNC_RELOAD = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_INIT_X       = 3'd0,
        CFG_INIT_Y       = 3'd1,
        CFG_INIT_WIDTH   = 3'd2,
        CFG_INIT_HEIGHT  = 3'd3,
        CFG_INIT_VISIBLE = 3'd4,
        CFG_WINDOW_ID    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [9:0] init_x;
        logic [9:0] init_y;
        logic [9:0] init_width;
        logic [9:0] init_height;
        logic       init_visible;
        logic [2:0] window_id;
    } t_cfg;

    typedef struct packed {
        t_func      func;
        logic [9:0] pointer_x;
        logic [9:0] pointer_y;
        logic       button_held;
        logic       left_before;
    } t_item;

    typedef struct packed {
        t_coord pos_x;
        t_coord pos_y;
        t_coord size_w;
        t_coord size_h;
        t_coord vel_x;
        t_coord vel_y;
        t_coord sav_x;
        t_coord sav_y;
        t_coord sav_w;
        t_coord sav_h;
        t_coord grab_x;
        t_coord grab_y;
        logic   vis;
        logic   min;
        logic   full;
        logic   drag;
    } t_win_state;

    typedef struct packed {
        t_coord      win_x;
        t_coord      win_y;
        logic [10:0] win_width;
        logic [10:0] win_height;
        logic        is_visible;
        logic        is_minimized;
        logic        is_fullscreen;
        logic        is_dragging;
        logic        focus_claim;
        logic [2:0]  focus_window;
    } t_result;

    function automatic t_wide ext(input t_coord c);
        return {{2{c[11]}}, c};
    endfunction

    function automatic t_wide ext_ptr(input logic [9:0] p);
        return {4'b0000, p};
    endfunction

    function automatic t_coord sat12(input t_wide v);
        t_coord r;
        if (v > SAT_HI) begin
            r = 12'h7FF;
        end else if (v < SAT_LO) begin
            r = 12'h800;
        end else begin
            r = v[11:0];
        end
        return r;
    endfunction

    function automatic logic hit(input t_wide px, input t_wide py, input t_wide rx,
                                 input t_wide ry, input t_wide rw, input t_wide rh);
        return (px >= rx) && (px < rx + rw) && (py >= ry) && (py < ry + rh);
    endfunction

    function automatic logic [11:0] magnitude(input t_coord v);
        return v[11] ? (12'(~v) + 12'd1) : 12'(v);
    endfunction

    // v*9/10, truncated toward zero
    function automatic t_coord scale_9_10(input t_coord v);
        logic [11:0] mag;
        logic [14:0] m9;
        logic [30:0] prod;
        logic [11:0] q;
        mag  = magnitude(v);
        m9   = {mag, 3'b000} + {3'b000, mag};
        prod = 31'(m9) * 31'(RECIP_10);
        q    = {1'b0, 11'(prod >> RECIP_SHIFT)};
        return v[11] ? (~q + 12'd1) : q;
    endfunction

    // -(v/2), truncated toward zero
    function automatic t_coord half_neg(input t_coord v);
        logic [11:0] mag;
        logic [11:0] h;
        mag = magnitude(v);
        h   = {1'b0, mag[11:1]};
        return v[11] ? h : (~h + 12'd1);
    endfunction

    function automatic logic [10:0] size_out(input t_coord s);
        return s[11] ? 11'd0 : s[10:0];
    endfunction

endpackage

@@ design/wdb_in_if.sv @@
interface wdb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [9:0] pointer_x;
    logic [9:0] pointer_y;
    logic       button_held;
    logic       left_before;

    modport source (
        output valid, func, pointer_x, pointer_y, button_held, left_before,
        input  ready
    );
    modport sink (
        input  valid, func, pointer_x, pointer_y, button_held, left_before,
        output ready
    );
endinterface

@@ design/wdb_out_if.sv @@
interface wdb_out_if;
    logic               valid;
    logic               ready;
    logic signed [11:0] win_x;
    logic signed [11:0] win_y;
    logic [10:0]        win_width;
    logic [10:0]        win_height;
    logic               is_visible;
    logic               is_minimized;
    logic               is_fullscreen;
    logic               is_dragging;
    logic               focus_claim;
    logic [2:0]         focus_window;

    modport source (
        output valid, win_x, win_y, win_width, win_height, is_visible, is_minimized,
               is_fullscreen, is_dragging, focus_claim, focus_window,
        input  ready
    );
    modport sink (
        input  valid, win_x, win_y, win_width, win_height, is_visible, is_minimized,
               is_fullscreen, is_dragging, focus_claim, focus_window,
        output ready
    );
endinterface

@@ design/wdb_cfg_regs.sv @@
module wdb_cfg_regs
    import wdb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_INIT_X:       n_cfg.init_x       = i_cfg_data[9:0];
                CFG_INIT_Y:       n_cfg.init_y       = i_cfg_data[9:0];
                CFG_INIT_WIDTH:   n_cfg.init_width   = i_cfg_data[9:0];
                CFG_INIT_HEIGHT:  n_cfg.init_height  = i_cfg_data[9:0];
                CFG_INIT_VISIBLE: n_cfg.init_visible = i_cfg_data[0];
                CFG_WINDOW_ID:    n_cfg.window_id    = i_cfg_data[2:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.init_x       <= 10'd10;
            r_cfg.init_y       <= 10'd10;
            r_cfg.init_width   <= 10'd300;
            r_cfg.init_height  <= 10'd70;
            r_cfg.init_visible <= 1'b1;
            r_cfg.window_id    <= 3'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ design/wdb_step.sv @@
module wdb_step
    import wdb_pkg::*;
(
    input  t_item      i_item,
    input  t_win_state i_state,
    input  t_cfg       i_cfg,
    output t_win_state o_state,
    output t_result    o_result
);

    t_win_state st;
    logic       claim;
    logic       press;
    t_wide      mx;
    t_wide      my;
    t_coord     nx;
    t_coord     ny;

    always_comb begin
        st    = i_state;
        claim = 1'b0;
        press = i_item.button_held && !i_item.left_before;
        mx    = ext_ptr(i_item.pointer_x);
        my    = ext_ptr(i_item.pointer_y);
        nx    = i_state.pos_x;
        ny    = i_state.pos_y;
        case (i_item.func)
            FUNC_TICK: begin
                if (st.vis && !st.min && !st.full) begin
                    st.pos_x = sat12(ext(st.pos_x) + ext(st.vel_x));
                    st.pos_y = sat12(ext(st.pos_y) + ext(st.vel_y));
                    st.vel_x = scale_9_10(st.vel_x);
                    st.vel_y = scale_9_10(st.vel_y);
                    // bounce: clamps run left, top, right, taskbar
                    if (st.pos_x[11]) begin
                        st.pos_x = '0;
                        st.vel_x = half_neg(st.vel_x);
                    end
                    if (st.pos_y[11]) begin
                        st.pos_y = '0;
                        st.vel_y = half_neg(st.vel_y);
                    end
                    if (ext(st.pos_x) + ext(st.size_w) > SCREEN_W_W) begin
                        st.pos_x = sat12(SCREEN_W_W - ext(st.size_w));
                        st.vel_x = half_neg(st.vel_x);
                    end
                    if (ext(st.pos_y) + ext(st.size_h) > FLOOR_Y) begin
                        st.pos_y = sat12(FLOOR_Y - ext(st.size_h));
                        st.vel_y = half_neg(st.vel_y);
                    end
                end
            end
            FUNC_MOUSE: begin
                if (st.vis) begin
                    claim = press && !st.min &&
                            hit(mx, my, ext(st.pos_x), ext(st.pos_y),
                                ext(st.size_w), ext(st.size_h));

                    if (press && hit(mx, my, ext(st.pos_x) + ext(st.size_w) - FULL_OFS_W,
                                     ext(st.pos_y) + BTN_TOP_OFS, BTN_W, BTN_W)) begin
                        if (!st.full) begin
                            st.sav_x  = st.pos_x;
                            st.sav_y  = st.pos_y;
                            st.sav_w  = st.size_w;
                            st.sav_h  = st.size_h;
                            st.pos_x  = '0;
                            st.pos_y  = '0;
                            st.size_w = FULL_W;
                            st.size_h = FULL_H;
                            st.vel_x  = '0;
                            st.vel_y  = '0;
                            st.full   = 1'b1;
                        end else begin
                            // restore keeps velocity
                            st.pos_x  = st.sav_x;
                            st.pos_y  = st.sav_y;
                            st.size_w = st.sav_w;
                            st.size_h = st.sav_h;
                            st.full   = 1'b0;
                        end
                    end

                    if (!st.drag && !st.full && press &&
                        hit(mx, my, ext(st.pos_x), ext(st.pos_y),
                            ext(st.size_w), TITLE_H_W)) begin
                        st.drag   = 1'b1;
                        st.grab_x = sat12(mx - ext(st.pos_x));
                        st.grab_y = sat12(my - ext(st.pos_y));
                        st.vel_x  = '0;
                        st.vel_y  = '0;
                    end

                    if (st.drag && i_item.button_held) begin
                        nx       = sat12(mx - ext(st.grab_x));
                        ny       = sat12(my - ext(st.grab_y));
                        st.vel_x = sat12(ext(nx) - ext(st.pos_x));
                        st.vel_y = sat12(ext(ny) - ext(st.pos_y));
                        st.pos_x = nx;
                        st.pos_y = ny;
                    end

                    if (st.drag && !i_item.button_held && i_item.left_before) begin
                        st.drag = 1'b0;
                    end

                    if (press && hit(mx, my, ext(st.pos_x) + ext(st.size_w) - CLOSE_OFS_W,
                                     ext(st.pos_y) + BTN_TOP_OFS, BTN_W, BTN_W)) begin
                        st.vis = 1'b0;
                    end

                    if (press && hit(mx, my, ext(st.pos_x) + ext(st.size_w) - MIN_OFS_W,
                                     ext(st.pos_y) + BTN_TOP_OFS, BTN_W, BTN_W)) begin
                        st.min = 1'b1;
                    end
                end
            end
            FUNC_RELOAD: begin
                // saved geometry and grab offset survive a reload
                st.pos_x  = {2'b00, i_cfg.init_x};
                st.pos_y  = {2'b00, i_cfg.init_y};
                st.size_w = {2'b00, i_cfg.init_width};
                st.size_h = {2'b00, i_cfg.init_height};
                st.vel_x  = '0;
                st.vel_y  = '0;
                st.vis    = i_cfg.init_visible;
                st.min    = 1'b0;
                st.full   = 1'b0;
                st.drag   = 1'b0;
            end
            default: begin
                st = i_state;
            end
        endcase
    end

    assign o_state = st;

    always_comb begin
        o_result.win_x         = st.pos_x;
        o_result.win_y         = st.pos_y;
        o_result.win_width     = size_out(st.size_w);
        o_result.win_height    = size_out(st.size_h);
        o_result.is_visible    = st.vis;
        o_result.is_minimized  = st.min;
        o_result.is_fullscreen = st.full;
        o_result.is_dragging   = st.drag;
        o_result.focus_claim   = claim;
        o_result.focus_window  = claim ? i_cfg.window_id : 3'd0;
    end

endmodule

@@ design/window_drag_bounce_controller.sv @@
// Channel   Dir  Handshake      Payload
// i_in      in   valid/ready    func, pointer_x, pointer_y, button_held, left_before
// o_out     out  valid/ready    win_x, win_y, win_width, win_height, flags, focus
// i_cfg_*   in   write enable   register index, write data
//
// Items pass the input and then the result register; one item per cycle unless o_out stalls.
// The window state register updates in the cycle an item moves from the input
// register to the result register, so each item sees the state its predecessor left.
// Reset is synchronous, active low; it loads the reset geometry and register values.
// A stalled result holds the result register; the input register still takes one
// more item, then ready drops until the result is taken.
module window_drag_bounce_controller
    import wdb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    wdb_in_if.sink                 i_in,
    wdb_out_if.source              o_out,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg       cfg;
    t_item      r_in;
    logic       r_in_valid;
    t_result    r_out;
    logic       r_out_valid;
    t_win_state r_state;
    t_win_state n_state;
    t_result    n_result;
    logic       advance;
    logic       in_take;

    wdb_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    wdb_step u_step (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_cfg    (cfg),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold payload registers until the transaction moves on
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.func        <= t_func'(i_in.func);
            r_in.pointer_x   <= i_in.pointer_x;
            r_in.pointer_y   <= i_in.pointer_y;
            r_in.button_held <= i_in.button_held;
            r_in.left_before <= i_in.left_before;
        end
        if (advance) begin
            r_out <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.pos_x  <= 12'sd10;
            r_state.pos_y  <= 12'sd10;
            r_state.size_w <= 12'sd300;
            r_state.size_h <= 12'sd70;
            r_state.vel_x  <= '0;
            r_state.vel_y  <= '0;
            r_state.sav_x  <= '0;
            r_state.sav_y  <= '0;
            r_state.sav_w  <= '0;
            r_state.sav_h  <= '0;
            r_state.grab_x <= '0;
            r_state.grab_y <= '0;
            r_state.vis    <= 1'b1;
            r_state.min    <= 1'b0;
            r_state.full   <= 1'b0;
            r_state.drag   <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.win_x         = r_out.win_x;
    assign o_out.win_y         = r_out.win_y;
    assign o_out.win_width     = r_out.win_width;
    assign o_out.win_height    = r_out.win_height;
    assign o_out.is_visible    = r_out.is_visible;
    assign o_out.is_minimized  = r_out.is_minimized;
    assign o_out.is_fullscreen = r_out.is_fullscreen;
    assign o_out.is_dragging   = r_out.is_dragging;
    assign o_out.focus_claim   = r_out.focus_claim;
    assign o_out.focus_window  = r_out.focus_window;

`ifndef SYNTHESIS
    a_state_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> (r_state == $past(r_state)))
        else $error("window state changed without a transaction");

    a_hidden_tick_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in.func == FUNC_TICK && !r_state.vis) |=> (r_state == $past(r_state)))
        else $error("tick changed a hidden window");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result register not loaded after advance");

    a_focus_id_needs_claim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.focus_claim) |-> (r_out.focus_window == 3'd0))
        else $error("window id reported without focus claim");

    a_size_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.size_w[11] && !r_state.size_h[11])
        else $error("window size went negative");
`endif

endmodule

@@ verif/wdb_state_checker.sv @@
module wdb_state_checker
    import wdb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    wdb_in_if                      i_in_ch,
    wdb_out_if                     i_out_ch,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_mismatches,
    output int                     o_pending,
    output int                     o_left,
    output int                     o_top,
    output int                     o_width,
    output int                     o_height
);

    localparam int FLOOR = SCREEN_HEIGHT - TASKBAR_HEIGHT;

    t_cfg    regs;
    int      pos_x, pos_y, size_w, size_h, vel_x, vel_y;
    int      sav_x, sav_y, sav_w, sav_h, grab_x, grab_y;
    bit      win_vis, win_min, win_full, win_drag;
    int      mismatches;
    t_result predicted_results[$];

    function automatic int clamp12(int v);
        if (v > 2047) return 2047;
        if (v < -2048) return -2048;
        return v;
    endfunction

    function automatic bit in_box(int px, int py, int rx, int ry, int rw, int rh);
        return px >= rx && px < rx + rw && py >= ry && py < ry + rh;
    endfunction

    function automatic logic [10:0] size_field(int s);
        if (s < 0) return 11'd0;
        if (s > 2047) return 11'd2047;
        return 11'(s);
    endfunction

    function automatic void reset_window();
        regs = '{10'd10, 10'd10, 10'd300, 10'd70, 1'b1, 3'd0};
        pos_x = 10;
        pos_y = 10;
        size_w = 300;
        size_h = 70;
        vel_x = 0;
        vel_y = 0;
        sav_x = 0;
        sav_y = 0;
        sav_w = 0;
        sav_h = 0;
        grab_x = 0;
        grab_y = 0;
        win_vis = 1'b1;
        win_min = 1'b0;
        win_full = 1'b0;
        win_drag = 1'b0;
    endfunction

    function automatic void write_register(logic [CFG_INDEX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        case (t_cfg_idx'(idx))
            CFG_INIT_X:       regs.init_x = data;
            CFG_INIT_Y:       regs.init_y = data;
            CFG_INIT_WIDTH:   regs.init_width = data;
            CFG_INIT_HEIGHT:  regs.init_height = data;
            CFG_INIT_VISIBLE: regs.init_visible = data[0];
            CFG_WINDOW_ID:    regs.window_id = data[2:0];
            default: ;
        endcase
    endfunction

    function automatic void reload_window();
        pos_x = int'(regs.init_x);
        pos_y = int'(regs.init_y);
        size_w = int'(regs.init_width);
        size_h = int'(regs.init_height);
        vel_x = 0;
        vel_y = 0;
        win_vis = regs.init_visible;
        win_min = 1'b0;
        win_full = 1'b0;
        win_drag = 1'b0;
    endfunction

    function automatic void advance_frame();
        if (!win_vis || win_min || win_full) return;
        pos_x = clamp12(pos_x + vel_x);
        pos_y = clamp12(pos_y + vel_y);
        vel_x = (vel_x * 9) / 10;
        vel_y = (vel_y * 9) / 10;
        // bounce order matters once the window is larger than the screen
        if (pos_x < 0) begin
            pos_x = 0;
            vel_x = clamp12(-vel_x / 2);
        end
        if (pos_y < 0) begin
            pos_y = 0;
            vel_y = clamp12(-vel_y / 2);
        end
        if (pos_x + size_w > SCREEN_WIDTH) begin
            pos_x = clamp12(SCREEN_WIDTH - size_w);
            vel_x = clamp12(-vel_x / 2);
        end
        if (pos_y + size_h > FLOOR) begin
            pos_y = clamp12(FLOOR - size_h);
            vel_y = clamp12(-vel_y / 2);
        end
    endfunction

    function automatic bit pointer_sample(int mx, int my, bit down, bit prior);
        bit press;
        bit claim;
        int nx, ny;
        press = down && !prior;
        claim = 1'b0;
        if (!win_vis) return 1'b0;
        if (press && !win_min && in_box(mx, my, pos_x, pos_y, size_w, size_h))
            claim = 1'b1;
        if (press && in_box(mx, my, pos_x + size_w - FULL_BTN_OFS, pos_y + 1,
                            BUTTON_SIZE, BUTTON_SIZE)) begin
            if (!win_full) begin
                sav_x = pos_x;
                sav_y = pos_y;
                sav_w = size_w;
                sav_h = size_h;
                pos_x = 0;
                pos_y = 0;
                size_w = clamp12(SCREEN_WIDTH);
                size_h = clamp12(FLOOR);
                vel_x = 0;
                vel_y = 0;
                win_full = 1'b1;
            end else begin
                // restore keeps the velocity
                pos_x = sav_x;
                pos_y = sav_y;
                size_w = sav_w;
                size_h = sav_h;
                win_full = 1'b0;
            end
        end
        if (!win_drag && !win_full && press &&
            in_box(mx, my, pos_x, pos_y, size_w, TITLE_HEIGHT)) begin
            win_drag = 1'b1;
            grab_x = clamp12(mx - pos_x);
            grab_y = clamp12(my - pos_y);
            vel_x = 0;
            vel_y = 0;
        end
        if (win_drag && down) begin
            nx = clamp12(mx - grab_x);
            ny = clamp12(my - grab_y);
            vel_x = clamp12(nx - pos_x);
            vel_y = clamp12(ny - pos_y);
            pos_x = nx;
            pos_y = ny;
        end
        if (win_drag && !down && prior)
            win_drag = 1'b0;
        if (press && in_box(mx, my, pos_x + size_w - CLOSE_BTN_OFS, pos_y + 1,
                            BUTTON_SIZE, BUTTON_SIZE))
            win_vis = 1'b0;
        if (press && in_box(mx, my, pos_x + size_w - MIN_BTN_OFS, pos_y + 1,
                            BUTTON_SIZE, BUTTON_SIZE))
            win_min = 1'b1;
        return claim;
    endfunction

    function automatic t_result window_step(t_item it);
        t_result r;
        bit      claim;
        claim = 1'b0;
        case (it.func)
            FUNC_TICK:   advance_frame();
            FUNC_MOUSE:  claim = pointer_sample(int'(it.pointer_x), int'(it.pointer_y),
                                                it.button_held, it.left_before);
            FUNC_RELOAD: reload_window();
            default: ;
        endcase
        r.win_x = t_coord'(pos_x);
        r.win_y = t_coord'(pos_y);
        r.win_width = size_field(size_w);
        r.win_height = size_field(size_h);
        r.is_visible = win_vis;
        r.is_minimized = win_min;
        r.is_fullscreen = win_full;
        r.is_dragging = win_drag;
        r.focus_claim = claim;
        r.focus_window = claim ? regs.window_id : 3'd0;
        return r;
    endfunction

    function automatic void compare_field(string field, logic signed [31:0] want,
                                          logic signed [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    initial begin
        mismatches = 0;
        reset_window();
    end

    always @(posedge i_clk) begin : watch
        t_item   it;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            reset_window();
            predicted_results.delete();
        end else begin
            if (i_cfg_we)
                write_register(i_cfg_index, i_cfg_data);
            // results trail their items through registers: check before predicting
            if (i_out_ch.valid && i_out_ch.ready) begin
                got.win_x = i_out_ch.win_x;
                got.win_y = i_out_ch.win_y;
                got.win_width = i_out_ch.win_width;
                got.win_height = i_out_ch.win_height;
                got.is_visible = i_out_ch.is_visible;
                got.is_minimized = i_out_ch.is_minimized;
                got.is_fullscreen = i_out_ch.is_fullscreen;
                got.is_dragging = i_out_ch.is_dragging;
                got.focus_claim = i_out_ch.focus_claim;
                got.focus_window = i_out_ch.focus_window;
                if (predicted_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result expected none, got x=%0d y=%0d", $time,
                             got.win_x, got.win_y);
                end else begin
                    want = predicted_results.pop_front();
                    compare_field("win_x", want.win_x, got.win_x);
                    compare_field("win_y", want.win_y, got.win_y);
                    compare_field("win_width", want.win_width, got.win_width);
                    compare_field("win_height", want.win_height, got.win_height);
                    compare_field("is_visible", want.is_visible, got.is_visible);
                    compare_field("is_minimized", want.is_minimized, got.is_minimized);
                    compare_field("is_fullscreen", want.is_fullscreen, got.is_fullscreen);
                    compare_field("is_dragging", want.is_dragging, got.is_dragging);
                    compare_field("focus_claim", want.focus_claim, got.focus_claim);
                    compare_field("focus_window", want.focus_window, got.focus_window);
                end
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                it.func = t_func'(i_in_ch.func);
                it.pointer_x = i_in_ch.pointer_x;
                it.pointer_y = i_in_ch.pointer_y;
                it.button_held = i_in_ch.button_held;
                it.left_before = i_in_ch.left_before;
                predicted_results.push_back(window_step(it));
            end
        end
        o_mismatches <= mismatches;
        o_pending <= predicted_results.size();
        o_left <= pos_x;
        o_top <= pos_y;
        o_width <= size_w;
        o_height <= size_h;
    end

endmodule

@@ verif/window_drag_bounce_controller_test.sv @@
module window_drag_bounce_controller_test;
    import wdb_pkg::*;

    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 175;
    localparam int SETTLE_CYCLES = 8;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int mismatches;
    int pending;
    int win_left;
    int win_top;
    int win_width;
    int win_height;
    bit calm;

    wdb_in_if  in_ch ();
    wdb_out_if out_ch ();

    window_drag_bounce_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    wdb_state_checker state_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_left       (win_left),
        .o_top        (win_top),
        .o_width      (win_width),
        .o_height     (win_height)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    function automatic int pick_wait();
        return calm ? 0 : int'($urandom_range(0, 15));
    endfunction

    function automatic logic [9:0] pixel(int v);
        if (v < 0) return 10'd0;
        if (v > 1023) return 10'd1023;
        return 10'(v);
    endfunction

    function automatic t_item mouse_item(int px, int py, bit down, bit prior);
        t_item it;
        it.func = FUNC_MOUSE;
        it.pointer_x = pixel(px);
        it.pointer_y = pixel(py);
        it.button_held = down;
        it.left_before = prior;
        return it;
    endfunction

    function automatic t_item plain_item(t_func f);
        t_item it;
        it.func = f;
        it.pointer_x = 10'($urandom_range(0, 1023));
        it.pointer_y = 10'($urandom_range(0, 1023));
        it.button_held = 1'($urandom_range(0, 1));
        it.left_before = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // aim the pointer at the window as last predicted
    function automatic t_item random_item();
        int roll;
        int px, py;
        int right;
        int w_span, h_span;
        bit down, prior;
        roll = $urandom_range(0, 99);
        if (roll < 28) return plain_item(FUNC_TICK);
        if (roll < 36) return plain_item(FUNC_RELOAD);
        if (roll < 41) return plain_item(FUNC_NOP);
        right = win_left + win_width;
        w_span = (win_width > 1) ? win_width - 1 : 0;
        h_span = (win_height > 1) ? win_height - 1 : 0;
        case ($urandom_range(0, 6))
            0: begin
                px = win_left + int'($urandom_range(0, w_span));
                py = win_top + int'($urandom_range(0, TITLE_HEIGHT - 1));
            end
            1: begin
                px = win_left + int'($urandom_range(0, w_span));
                py = win_top + int'($urandom_range(0, h_span));
            end
            2, 3: begin
                px = right - CLOSE_BTN_OFS * int'($urandom_range(1, 3))
                     + int'($urandom_range(0, BUTTON_SIZE - 1));
                py = win_top + 1 + int'($urandom_range(0, BUTTON_SIZE - 1));
            end
            4: begin
                px = right - int'($urandom_range(0, 40));
                py = win_top + int'($urandom_range(0, 11)) - 1;
            end
            default: begin
                px = $urandom_range(0, 1023);
                py = $urandom_range(0, 1023);
            end
        endcase
        roll = $urandom_range(0, 9);
        down = roll < 7;
        prior = roll >= 4 && roll < 9;
        return mouse_item(px, py, down, prior);
    endfunction

    task automatic send_item(input t_item it);
        int gap;
        gap = pick_wait();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func <= it.func;
        in_ch.pointer_x <= it.pointer_x;
        in_ch.pointer_y <= it.pointer_y;
        in_ch.button_held <= it.button_held;
        in_ch.left_before <= it.left_before;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
    endtask

    // hold the input until every predicted result has been taken
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic cfg_put(input t_cfg_idx idx, input int value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
    endtask

    task automatic configure(input int x, input int y, input int w, input int h,
                             input int vis, input int id);
        cfg_put(CFG_INIT_X, x);
        cfg_put(CFG_INIT_Y, y);
        cfg_put(CFG_INIT_WIDTH, w);
        cfg_put(CFG_INIT_HEIGHT, h);
        cfg_put(CFG_INIT_VISIBLE, vis);
        cfg_put(CFG_WINDOW_ID, id);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            int stall;
            stall = pick_wait();
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
        end
    end

    initial begin : stimulus
        calm = 1'b0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.func <= FUNC_NOP;
        in_ch.pointer_x <= '0;
        in_ch.pointer_y <= '0;
        in_ch.button_held <= 1'b0;
        in_ch.left_before <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: 300x70 at (10,10)
        send_item(plain_item(FUNC_NOP));
        send_item(plain_item(FUNC_TICK));
        send_item(mouse_item(60, 12, 1'b1, 1'b0));
        send_item(mouse_item(0, 0, 1'b1, 1'b1));
        send_item(plain_item(FUNC_TICK));
        send_item(mouse_item(1023, 1023, 1'b1, 1'b1));
        send_item(mouse_item(1023, 1023, 1'b0, 1'b1));
        send_item(plain_item(FUNC_TICK));
        send_item(plain_item(FUNC_RELOAD));
        send_item(mouse_item(283, 14, 1'b1, 1'b0));
        send_item(plain_item(FUNC_TICK));
        send_item(mouse_item(290, 1, 1'b1, 1'b0));
        send_item(mouse_item(297, 18, 1'b1, 1'b0));
        send_item(plain_item(FUNC_TICK));
        send_item(mouse_item(100, 50, 1'b0, 1'b0));
        send_item(mouse_item(100, 50, 1'b1, 1'b1));
        send_item(plain_item(FUNC_RELOAD));
        send_item(mouse_item(307, 18, 1'b1, 1'b0));
        send_item(mouse_item(50, 50, 1'b1, 1'b0));
        send_item(plain_item(FUNC_TICK));
        send_item(plain_item(FUNC_RELOAD));
        drain();
        // window larger than the screen ends with negative edges
        configure(1023, 1023, 1023, 1023, 1, 7);
        send_item(plain_item(FUNC_RELOAD));
        send_item(plain_item(FUNC_TICK));
        send_item(mouse_item(0, 0, 1'b1, 1'b0));
        drain();
        configure(0, 0, 1, 1, 0, 0);
        send_item(plain_item(FUNC_RELOAD));
        send_item(mouse_item(0, 0, 1'b1, 1'b0));

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: configure(1023, 1023, 1023, 1023, 1, 7);
                1: configure(0, 0, 1, 1, 1, 0);
                default: begin
                    if ($urandom_range(0, 3) != 0)
                        configure($urandom_range(0, 120), $urandom_range(0, 100),
                                  $urandom_range(30, 319), $urandom_range(20, 180),
                                  $urandom_range(0, 7) != 0, $urandom_range(0, 7));
                    else
                        configure($urandom_range(0, 1023), $urandom_range(0, 1023),
                                  $urandom_range(1, 1023), $urandom_range(1, 1023),
                                  $urandom_range(0, 1), $urandom_range(0, 7));
                end
            endcase
            send_item(plain_item(FUNC_RELOAD));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                send_item(random_item());
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
design/wdb_pkg.sv
design/wdb_in_if.sv
design/wdb_out_if.sv
design/wdb_cfg_regs.sv
design/wdb_step.sv
design/window_drag_bounce_controller.sv
verif/wdb_state_checker.sv
verif/window_drag_bounce_controller_test.sv
